/* rtl/core/b2d_pkg.sv */
// ---------------------------------------------------------------------------
// b2d_pkg
// Shared types, constants and the power-of-ten table for the binary to
// decimal ASCII converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2d_pkg;

    localparam int DIGITS = 10;
    localparam int SLOTS  = 11;
    localparam int MULT_W = 34;     // 9 * 10^9 needs 34 bits

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_MINUS = 6'd45;

    // Work word carried down the pipe. digits[0] is the 10^9 place.
    typedef struct packed {
        logic                   neg;
        logic [31:0]            rem;
        logic [DIGITS-1:0][3:0] digits;
        logic [3:0]             cnt;    // significant digits so far
    } t_work;

    // d * 10^pos, elaborated as a constant table
    function automatic logic [MULT_W-1:0] f_mult(input int unsigned pos,
                                                 input int unsigned d);
        longint unsigned acc;
        acc = longint'(d);
        for (int i = 0; i < int'(pos); i++) begin
            acc = acc * 64'd10;
        end
        return acc[MULT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/b2d_in_if.sv */
// ---------------------------------------------------------------------------
// b2d_in_if
// Input channel: 32-bit value and signed/unsigned mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b2d_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

`default_nettype wire

/* rtl/core/b2d_out_if.sv */
// ---------------------------------------------------------------------------
// b2d_out_if
// Output channel: text length and eleven left-justified character slots.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b2d_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] text_len;
    logic [5:0] char_0;
    logic [5:0] char_1;
    logic [5:0] char_2;
    logic [5:0] char_3;
    logic [5:0] char_4;
    logic [5:0] char_5;
    logic [5:0] char_6;
    logic [5:0] char_7;
    logic [5:0] char_8;
    logic [5:0] char_9;
    logic [5:0] char_10;

    modport source (output valid, output text_len, output char_0, output char_1,
                    output char_2, output char_3, output char_4, output char_5,
                    output char_6, output char_7, output char_8, output char_9,
                    output char_10, input ready);
    modport sink   (input valid, input text_len, input char_0, input char_1,
                    input char_2, input char_3, input char_4, input char_5,
                    input char_6, input char_7, input char_8, input char_9,
                    input char_10, output ready);
endinterface

`default_nettype wire

/* rtl/core/binary_to_decimal_ascii.sv */
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// 32-bit binary to ASCII decimal text, unsigned or two's complement signed.
//
//   channel  dir  handshake     word
//   i_in     in   valid/ready   value[31:0], mode
//   o_out    out  valid/ready   text_len[3:0], char_0..char_10[5:0]
//
// Twelve register stages: sign/magnitude, ten digit stages (10^9 down to
// units, one parallel compare-and-subtract each), then formatting.
// One word accepted per cycle when the output drains.
// Reset clears only the stage valid bits; no clearing pass.
// A stall at o_out backs up stage by stage; empty stages keep filling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii
    import b2d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b2d_in_if.sink     i_in,
    b2d_out_if.source  o_out
);

    t_work           work  [DIGITS+1];
    logic [DIGITS:0] vld;
    logic [DIGITS:0] rdy;

    b2d_sign u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_work  (work[0]),
        .o_valid (vld[0]),
        .i_ready (rdy[0])
    );

    for (genvar k = 0; k < DIGITS; k++) begin : g_digit
        b2d_digit #(
            .POS (DIGITS - 1 - k)
        ) u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_work  (work[k]),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .o_work  (work[k+1]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1])
        );
    end

    b2d_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (work[DIGITS]),
        .i_valid (vld[DIGITS]),
        .o_ready (rdy[DIGITS]),
        .o_out   (o_out)
    );

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.text_len >= 4'd1 && o_out.text_len <= 4'd11))
        else $error("text length out of range");

    a_first_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.char_0 == ASCII_MINUS ||
                         (o_out.char_0 >= 6'd48 && o_out.char_0 <= 6'd57)))
        else $error("first character neither sign nor digit");

    a_eleven_signed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.text_len == 4'd11) |-> o_out.char_0 == ASCII_MINUS)
        else $error("eleven characters without a sign");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_10 != 6'd0) |-> o_out.text_len == 4'd11)
        else $error("last slot filled beyond text length");

    a_units_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[DIGITS] |-> work[DIGITS].cnt != 4'd0)
        else $error("no significant digit after units stage");

endmodule

`default_nettype wire

/* rtl/core/b2d_sign.sv */
// ---------------------------------------------------------------------------
// b2d_sign
// Entry stage: takes the input word, splits off the sign and forms the
// magnitude.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2d_sign
    import b2d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    b2d_in_if.sink     i_in,
    output t_work      o_work,
    output logic       o_valid,
    input  wire logic  i_ready
);

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  up_ready;

    assign up_ready   = !r_valid || i_ready;
    assign i_in.ready = up_ready;

    always_comb begin
        n_work        = '0;
        n_work.neg    = i_in.mode & i_in.value[31];
        // most negative value wraps to 2^31, which is the right magnitude
        n_work.rem    = n_work.neg ? (~i_in.value + 32'd1) : i_in.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (up_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (up_ready && i_in.valid) begin
            r_work <= n_work;
        end
    end

    assign o_work  = r_work;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/core/b2d_digit.sv */
// ---------------------------------------------------------------------------
// b2d_digit
// One digit stage: finds the digit for place 10^POS by comparing the
// remainder against the nine multiples in parallel, then subtracts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2d_digit
    import b2d_pkg::*;
#(
    parameter int unsigned POS = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_work i_work,
    input  wire logic  i_valid,
    output logic       o_ready,
    output t_work      o_work,
    output logic       o_valid,
    input  wire logic  i_ready
);

    localparam int SLOT = DIGITS - 1 - int'(POS);

    logic              r_valid;
    t_work             r_work;
    t_work             n_work;
    logic [MULT_W-1:0] rem_x;
    logic [MULT_W-1:0] sub;
    logic [MULT_W-1:0] diff;
    logic [3:0]        dig;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        rem_x = {{(MULT_W-32){1'b0}}, i_work.rem};
        dig   = 4'd0;
        sub   = '0;
        for (int d = 1; d < 10; d++) begin
            if (rem_x >= f_mult(POS, d)) begin
                dig = 4'(d);
                sub = f_mult(POS, d);
            end
        end
        diff   = rem_x - sub;
        n_work = i_work;
        n_work.rem = diff[31:0];
        n_work.digits[SLOT] = dig;
        // units place always counts, so zero prints as one digit
        if (i_work.cnt != 4'd0 || dig != 4'd0 || POS == 0) begin
            n_work.cnt = i_work.cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_work  = r_work;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/core/b2d_format.sv */
// ---------------------------------------------------------------------------
// b2d_format
// Output stage: drops leading zeros, places the sign and left-justifies the
// digits into the eleven character slots.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b2d_format
    import b2d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_work i_work,
    input  wire logic  i_valid,
    output logic       o_ready,
    b2d_out_if.source  o_out
);

    logic                 r_valid;
    logic [3:0]           r_len;
    logic [SLOTS-1:0][5:0] r_chars;
    logic [3:0]           n_len;
    logic [SLOTS-1:0][5:0] n_chars;
    logic [4:0]           idx;
    logic [4:0]           pick;

    assign o_ready = !r_valid || o_out.ready;

    always_comb begin
        n_len   = {3'd0, i_work.neg} + i_work.cnt;
        n_chars = '0;
        idx     = '0;
        pick    = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (i_work.neg && j == 0) begin
                n_chars[j] = ASCII_MINUS;
            end else begin
                idx  = 5'(j) - {4'd0, i_work.neg};
                // first significant digit sits at DIGITS - cnt
                pick = 5'(DIGITS) - {1'b0, i_work.cnt} + idx;
                if (idx < {1'b0, i_work.cnt}) begin
                    n_chars[j] = ASCII_ZERO + {2'b00, i_work.digits[pick[3:0]]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_len   <= n_len;
            r_chars <= n_chars;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.text_len = r_len;
    assign o_out.char_0   = r_chars[0];
    assign o_out.char_1   = r_chars[1];
    assign o_out.char_2   = r_chars[2];
    assign o_out.char_3   = r_chars[3];
    assign o_out.char_4   = r_chars[4];
    assign o_out.char_5   = r_chars[5];
    assign o_out.char_6   = r_chars[6];
    assign o_out.char_7   = r_chars[7];
    assign o_out.char_8   = r_chars[8];
    assign o_out.char_9   = r_chars[9];
    assign o_out.char_10  = r_chars[10];

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Checks binary_to_decimal_ascii. Each input word is predicted in the bench
// and compared slot by slot with the words that come out, in order. Directed
// extremes come first, then random values under changing idle patterns and
// one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import b2d_pkg::*;

    typedef struct packed {
        logic [3:0]            len;
        logic [SLOTS-1:0][5:0] chars;
    } t_text;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    b2d_in_if  in_ch ();
    b2d_out_if out_ch ();

    binary_to_decimal_ascii dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_text expected_texts [$];
    int    error_count   = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_cycles   = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.mode   = 1'b0;
        out_ch.ready = 1'b0;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready = 1'b0;
            hold_cycles  = hold_cycles - 1;
        end else begin
            out_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Decimal text of a value, worked out digit by digit from the units up
    function automatic t_text decimal_text(input logic [31:0] value, input logic mode);
        t_text       txt;
        logic [31:0] mag;
        logic [3:0]  units_first [10];
        int          n;
        int          pos;
        txt = '0;
        mag = value;
        pos = 0;
        if (mode && value[31]) begin
            mag = ~value + 32'd1;
            txt.chars[0] = ASCII_MINUS;
            pos = 1;
        end
        n = 0;
        do begin
            units_first[n] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            n++;
        end while (mag != 0);
        for (int k = n - 1; k >= 0; k--) begin
            txt.chars[pos] = ASCII_ZERO + 6'(units_first[k]);
            pos++;
        end
        txt.len = 4'(pos);
        return txt;
    endfunction

    function automatic t_text output_text();
        t_text txt;
        txt.len       = out_ch.text_len;
        txt.chars[0]  = out_ch.char_0;
        txt.chars[1]  = out_ch.char_1;
        txt.chars[2]  = out_ch.char_2;
        txt.chars[3]  = out_ch.char_3;
        txt.chars[4]  = out_ch.char_4;
        txt.chars[5]  = out_ch.char_5;
        txt.chars[6]  = out_ch.char_6;
        txt.chars[7]  = out_ch.char_7;
        txt.chars[8]  = out_ch.char_8;
        txt.chars[9]  = out_ch.char_9;
        txt.chars[10] = out_ch.char_10;
        return txt;
    endfunction

    always @(posedge clk) begin : check_text
        t_text got;
        t_text want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = output_text();
            if (expected_texts.size() == 0) begin
                $error("unexpected output word, text_len %0d", got.len);
                error_count++;
            end else begin
                want = expected_texts.pop_front();
                if (got.len !== want.len) begin
                    $error("text_len: expected %0d, actual %0d", want.len, got.len);
                    error_count++;
                end
                for (int k = 0; k < SLOTS; k++) begin
                    if (got.chars[k] !== want.chars[k]) begin
                        $error("char_%0d: expected %0d, actual %0d",
                               k, want.chars[k], got.chars[k]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Called and returns at a falling edge; valid is left high after the
    // handshake so back-to-back words need no drop in between.
    task automatic send_number(input logic [31:0] value, input logic mode);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = value;
        in_ch.mode  = mode;
        do @(posedge clk); while (!in_ch.ready);
        expected_texts.push_back(decimal_text(value, mode));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (expected_texts.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Spread over all digit counts, powers of ten and the sign boundary
    function automatic logic [31:0] random_number();
        logic [31:0] p;
        int          k;
        case ($urandom_range(4, 0))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom >> $urandom_range(31, 0);
            end
            2: begin
                p = 32'd1;
                k = $urandom_range(9, 0);
                repeat (k) p = p * 32'd10;
                p = p + 32'($urandom_range(2, 0)) - 32'd1;
                return $urandom_range(1, 0) ? p : -p;
            end
            3: begin
                return 32'h8000_0000 + 32'($urandom_range(4, 0)) - 32'd2;
            end
            default: begin
                return -($urandom >> $urandom_range(31, 0));
            end
        endcase
    endfunction

    task automatic test_directed();
        send_number(32'd0,          1'b0);
        send_number(32'd0,          1'b1);
        send_number(32'hFFFF_FFFF,  1'b0);
        send_number(32'hFFFF_FFFF,  1'b1);
        send_number(32'h8000_0000,  1'b1);   // most negative
        send_number(32'h8000_0000,  1'b0);
        send_number(32'h7FFF_FFFF,  1'b1);
        send_number(32'h7FFF_FFFF,  1'b0);
        send_number(32'h8000_0001,  1'b1);
        send_number(32'd1,          1'b1);
        send_number(32'd9,          1'b0);
        send_number(32'd10,         1'b0);
        send_number(32'd99,         1'b1);
        send_number(32'd100,        1'b0);
        send_number(32'd999999999,  1'b0);
        send_number(32'd1000000000, 1'b1);
        send_number(32'd4000000000, 1'b0);
        send_number(-32'd1000000000, 1'b1);
        send_number(-32'd999999999, 1'b1);
        send_number(-32'd10,        1'b1);
        send_number(-32'd9,         1'b1);
        send_number(32'hAAAA_AAAA,  1'b0);
        send_number(32'h5555_5555,  1'b1);
        wait_idle();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_number(random_number(), 1'($urandom_range(1, 0)));
        wait_idle();
    endtask

    // Long output stall while words keep coming, so the pipe fills and
    // pushes back on the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 150;
        repeat (40) send_number(random_number(), 1'($urandom_range(1, 0)));
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 73;
        test_directed();
        test_random(620);

        send_idle_pct = 73;
        recv_idle_pct = 18;
        test_random(620);

        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(620);

        repeat (24) @(posedge clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/b2d_pkg.sv
rtl/core/b2d_in_if.sv
rtl/core/b2d_out_if.sv
rtl/core/b2d_sign.sv
rtl/core/b2d_digit.sv
rtl/core/b2d_format.sv
rtl/core/binary_to_decimal_ascii.sv
tb/testbench.sv
